// ===== hdl/windowed_mean_stderr_calibrator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef WINDOWED_MEAN_STDERR_CALIBRATOR_ASSERT_SVH
`define WINDOWED_MEAN_STDERR_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define WMSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define WMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wmsc_pkg.sv =====
package wmsc_pkg;

    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int FIELD_W     = 24;
    localparam int COUNT_OUT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 16;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd46137;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'hEAB1;   // -5455

    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_NSQ,
        BK_MUL_SSQ,
        BK_MUL_NN,
        BK_MUL_N3,
        BK_DIV_MEAN,
        BK_DIV_SE,
        BK_SQRT,
        BK_CAL,
        BK_OUT
    } back_state_t;

endpackage

// ===== hdl/wmsc_in_if.sv =====
interface wmsc_in_if;
    import wmsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] sample;
    logic               include_req;
    logic               window_end;

    modport source (output valid, sample, include_req, window_end, input ready);
    modport sink   (input valid, sample, include_req, window_end, output ready);
endinterface

// ===== hdl/wmsc_out_if.sv =====
interface wmsc_out_if;
    import wmsc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_W-1:0]     window_mean;
    logic [FIELD_W-1:0]     std_error;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic [FIELD_W-1:0]     calibrated_current;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, window_mean, std_error, sample_count,
                    calibrated_current, status, input ready);
    modport sink   (input valid, window_mean, std_error, sample_count,
                    calibrated_current, status, output ready);
endinterface

// ===== hdl/windowed_mean_stderr_calibrator.sv =====
// Windowed mean / standard error / calibrated current.
// samples: valid/ready channel of rate readings (unsigned Q16.8) with an
// include flag and a window-end flag. results: one item per window-end
// transfer with mean, standard error, count, calibrated current, status.
// cfg_we/cfg_index/cfg_data write cal_gain (index 0) and cal_offset (1);
// write only while no window is in flight.
// Throughput: one sample per cycle; the front accumulates sum, sum of
// squares and count with one squarer. Closed windows go to a 2-entry queue;
// samples stall only while two closed windows wait there.
// After a window-end transfer the bit-serial multiplier forms n*sumsq,
// sum^2, n^2 and n^3, the divider forms the mean and diff/n^3, and the
// root unit takes the standard error; the calibration step follows.
// An empty window skips these units and returns zero fields, status empty.
// Reset clears the accumulators, the queue and the back end, and loads the
// calibration defaults. A stalled result holds on the output register while
// the front keeps taking samples until the queue fills.
module windowed_mean_stderr_calibrator #(
    parameter int MAX_WINDOW  = wmsc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wmsc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    wmsc_in_if.sink                        samples,
    wmsc_out_if.source                     results,
    input  logic                           cfg_we,
    input  logic [wmsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wmsc_pkg::CFG_W-1:0]     cfg_data
);
    import wmsc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SNAP_W = 1 + CNT_W + (2 * SAMPLE_BITS + CNT_W) + (SAMPLE_BITS + CNT_W);

    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic              push;
    logic [SNAP_W-1:0] push_data;
    logic              full;
    logic              pop;
    logic              not_empty;
    logic [SNAP_W-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAL_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_CAL_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:        ;
            endcase
        end
    end

    wmsc_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SNAP_W     (SNAP_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (samples),
        .push     (push),
        .push_data(push_data),
        .full     (full)
    );

    wmsc_queue #(
        .WIDTH(SNAP_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .pop_data (pop_data)
    );

    wmsc_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SNAP_W     (SNAP_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .cal_gain  (gain_reg),
        .cal_offset(offset_reg),
        .out_ch    (results)
    );
endmodule

// ===== hdl/wmsc_queue.sv =====
module wmsc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hdl/wmsc_front.sv =====
module wmsc_front #(
    parameter int MAX_WINDOW  = wmsc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wmsc_pkg::SAMPLE_BITS_DEF,
    parameter int SNAP_W      = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    wmsc_in_if.sink           in_ch,
    output logic              push,
    output logic [SNAP_W-1:0] push_data,
    input  logic              full
);
    import wmsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int SW    = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             drop_reg, drop_next;

    logic [SAMPLE_BITS-1:0] s;
    logic                   room;
    logic                   take;
    logic                   xfer;

    assign in_ch.ready = !full;
    assign xfer        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s         = SAMPLE_BITS'(in_ch.sample[SW-1:0]);
        room      = (cnt_reg < CNT_W'(MAX_WINDOW));
        take      = in_ch.include_req && room;
        sum_next  = sum_reg + (take ? SUM_W'(s) : '0);
        sq_next   = sq_reg + (take ? SQ_W'(s) * SQ_W'(s) : '0);
        cnt_next  = cnt_reg + CNT_W'(take);
        drop_next = drop_reg || (in_ch.include_req && !room);
    end

    assign push      = xfer && in_ch.window_end;
    assign push_data = {drop_next, cnt_next, sq_next, sum_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (xfer)
        begin
            if (in_ch.window_end)
            begin
                sum_reg  <= '0;
                sq_reg   <= '0;
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else
            begin
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
                cnt_reg  <= cnt_next;
                drop_reg <= drop_next;
            end
        end
    end
endmodule

// ===== hdl/wmsc_back.sv =====
module wmsc_back #(
    parameter int MAX_WINDOW  = wmsc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wmsc_pkg::SAMPLE_BITS_DEF,
    parameter int SNAP_W      = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [SNAP_W-1:0]               q_data,
    output logic                            q_pop,
    input  logic [wmsc_pkg::GAIN_W-1:0]     cal_gain,
    input  logic [wmsc_pkg::OFFSET_W-1:0]   cal_offset,
    wmsc_out_if.source                      out_ch
);
    import wmsc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
    localparam int WIDE_W = SQ_W + CNT_W;
    localparam int N3_W   = 3 * CNT_W;
    localparam int ROOT_W = WIDE_W / 2;
    localparam int STEP_W = $clog2(WIDE_W + 1);
    localparam int EXT_W  = WIDE_W + FIELD_W;
    localparam int PROD_W = GAIN_W + FIELD_W;
    localparam int CUR_W  = FIELD_W + 2;

    localparam logic [EXT_W-1:0] FIELD_MAX_EXT = EXT_W'({FIELD_W{1'b1}});
    localparam logic [EXT_W-1:0] COUNT_MAX_EXT = EXT_W'({COUNT_OUT_W{1'b1}});

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  n_reg;
    logic              drop_reg;

    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] mop_reg;
    logic [SUM_W-1:0]  mbits_reg;
    logic [WIDE_W-1:0] nsq_reg;
    logic [WIDE_W-1:0] diff_reg;
    logic [SUM_W-1:0]  mean_reg;

    logic [WIDE_W-1:0] dvd_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [N3_W:0]     rem_reg;
    logic [N3_W-1:0]   dvs_reg;

    logic [WIDE_W-1:0]   rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+1:0]   srem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [FIELD_W-1:0]     mean_o_reg;
    logic [FIELD_W-1:0]     se_o_reg;
    logic [COUNT_OUT_W-1:0] cnt_o_reg;
    logic [FIELD_W-1:0]     cur_o_reg;
    logic [STATUS_W-1:0]    status_o_reg;

    logic [SUM_W-1:0]  q_sum;
    logic [SQ_W-1:0]   q_sq;
    logic [CNT_W-1:0]  q_n;
    logic              q_drop;

    logic [WIDE_W-1:0] mul_sum;
    logic [N3_W:0]     rem_sh;
    logic              div_ge;
    logic [N3_W:0]     rem_new;
    logic [WIDE_W-1:0] quo_new;
    logic [ROOT_W+1:0] srem_sh;
    logic [ROOT_W+1:0] trial;
    logic              sq_ge;
    logic [ROOT_W+1:0] srem_new;
    logic [ROOT_W-1:0] root_new;
    logic              step_last;

    logic [EXT_W-1:0]   mean_ext;
    logic [EXT_W-1:0]   root_ext;
    logic [EXT_W-1:0]   n_ext;
    logic [FIELD_W-1:0] mean_sat;
    logic [FIELD_W-1:0] root_sat;
    logic [COUNT_OUT_W-1:0] cnt_sat;
    logic [CUR_W-1:0]   cur_sum;
    logic [FIELD_W-1:0] cur_sat;

    assign {q_drop, q_n, q_sq, q_sum} = q_data;

    always_comb
    begin
        // shift-add multiply, one multiplier bit a cycle, MSB first
        mul_sum = {acc_reg[WIDE_W-2:0], 1'b0} + (mbits_reg[SUM_W-1] ? mop_reg : '0);

        // restoring divide, one quotient bit a cycle
        rem_sh  = {rem_reg[N3_W-1:0], dvd_reg[WIDE_W-1]};
        div_ge  = (rem_sh >= {1'b0, dvs_reg});
        rem_new = div_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        quo_new = {quo_reg[WIDE_W-2:0], div_ge};

        // digit-by-digit square root, one root bit a cycle
        srem_sh  = {srem_reg[ROOT_W-1:0], rad_reg[WIDE_W-1:WIDE_W-2]};
        trial    = {root_reg, 2'b01};
        sq_ge    = (srem_sh >= trial);
        srem_new = sq_ge ? (srem_sh - trial) : srem_sh;
        root_new = {root_reg[ROOT_W-2:0], sq_ge};

        step_last = (step_reg == STEP_W'(1));

        mean_ext = EXT_W'(mean_reg);
        root_ext = EXT_W'(root_new);
        n_ext    = EXT_W'(n_reg);
        mean_sat = (mean_ext > FIELD_MAX_EXT) ? {FIELD_W{1'b1}} : mean_ext[FIELD_W-1:0];
        root_sat = (root_ext > FIELD_MAX_EXT) ? {FIELD_W{1'b1}} : root_ext[FIELD_W-1:0];
        cnt_sat  = (n_ext > COUNT_MAX_EXT) ? {COUNT_OUT_W{1'b1}} : n_ext[COUNT_OUT_W-1:0];

        cur_sum = {2'b00, prod_reg[PROD_W-1:GAIN_W]}
                + {{(CUR_W-OFFSET_W){cal_offset[OFFSET_W-1]}}, cal_offset};
        if (!cur_sum[CUR_W-1] && (cur_sum[CUR_W-2:FIELD_W-1] != 2'b00))
        begin
            cur_sat = {1'b0, {(FIELD_W-1){1'b1}}};
        end
        else if (cur_sum[CUR_W-1] && (cur_sum[CUR_W-2:FIELD_W-1] != 2'b11))
        begin
            cur_sat = {1'b1, {(FIELD_W-1){1'b0}}};
        end
        else
        begin
            cur_sat = cur_sum[FIELD_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_n == '0) ? BK_OUT : BK_MUL_NSQ;
                end
            end
            BK_MUL_NSQ:  if (step_last) state_next = BK_MUL_SSQ;
            BK_MUL_SSQ:  if (step_last) state_next = BK_MUL_NN;
            BK_MUL_NN:   if (step_last) state_next = BK_MUL_N3;
            BK_MUL_N3:   if (step_last) state_next = BK_DIV_MEAN;
            BK_DIV_MEAN: if (step_last) state_next = BK_DIV_SE;
            BK_DIV_SE:   if (step_last) state_next = BK_SQRT;
            BK_SQRT:     if (step_last) state_next = BK_CAL;
            BK_CAL:      state_next = BK_OUT;
            BK_OUT:      if (out_ch.ready) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop                     = (state_reg == BK_IDLE);
        out_ch.valid              = (state_reg == BK_OUT);
        out_ch.window_mean        = mean_o_reg;
        out_ch.std_error          = se_o_reg;
        out_ch.sample_count       = cnt_o_reg;
        out_ch.calibrated_current = cur_o_reg;
        out_ch.status             = status_o_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:     step_reg <= STEP_W'(SUM_W);
                BK_MUL_NSQ,
                BK_MUL_SSQ,
                BK_MUL_NN:   step_reg <= step_last ? STEP_W'(SUM_W) : step_reg - 1'b1;
                BK_MUL_N3,
                BK_DIV_MEAN: step_reg <= step_last ? STEP_W'(WIDE_W) : step_reg - 1'b1;
                BK_DIV_SE:   step_reg <= step_last ? STEP_W'(ROOT_W) : step_reg - 1'b1;
                BK_SQRT:     step_reg <= step_reg - 1'b1;
                default:     step_reg <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                sum_reg   <= q_sum;
                n_reg     <= q_n;
                drop_reg  <= q_drop;
                acc_reg   <= '0;
                mop_reg   <= WIDE_W'(q_sq);
                mbits_reg <= SUM_W'(q_n);
                mean_o_reg   <= '0;
                se_o_reg     <= '0;
                cnt_o_reg    <= '0;
                cur_o_reg    <= '0;
                status_o_reg <= STATUS_EMPTY;
            end
            BK_MUL_NSQ, BK_MUL_SSQ, BK_MUL_NN, BK_MUL_N3:
            begin
                if (step_last)
                begin
                    acc_reg <= '0;
                    case (state_reg)
                        BK_MUL_NSQ:
                        begin
                            nsq_reg   <= mul_sum;
                            mop_reg   <= WIDE_W'(sum_reg);
                            mbits_reg <= sum_reg;
                        end
                        BK_MUL_SSQ:
                        begin
                            // a negative spread reads as zero
                            diff_reg  <= (nsq_reg >= mul_sum) ? (nsq_reg - mul_sum) : '0;
                            mop_reg   <= WIDE_W'(n_reg);
                            mbits_reg <= SUM_W'(n_reg);
                        end
                        BK_MUL_NN:
                        begin
                            mop_reg   <= mul_sum;
                            mbits_reg <= SUM_W'(n_reg);
                        end
                        default:
                        begin
                            // n^3 waits in mop_reg while the sum is divided by n
                            mop_reg <= mul_sum;
                            dvs_reg <= N3_W'(n_reg);
                            dvd_reg <= WIDE_W'(sum_reg);
                            rem_reg <= '0;
                            quo_reg <= '0;
                        end
                    endcase
                end
                else
                begin
                    acc_reg   <= mul_sum;
                    mbits_reg <= {mbits_reg[SUM_W-2:0], 1'b0};
                end
            end
            BK_DIV_MEAN, BK_DIV_SE:
            begin
                if (step_last)
                begin
                    if (state_reg == BK_DIV_MEAN)
                    begin
                        mean_reg <= quo_new[SUM_W-1:0];
                        dvd_reg  <= diff_reg;
                        dvs_reg  <= mop_reg[N3_W-1:0];
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                    end
                    else
                    begin
                        rad_reg  <= quo_new;
                        root_reg <= '0;
                        srem_reg <= '0;
                    end
                end
                else
                begin
                    dvd_reg <= {dvd_reg[WIDE_W-2:0], 1'b0};
                    rem_reg <= rem_new;
                    quo_reg <= quo_new;
                end
            end
            BK_SQRT:
            begin
                rad_reg  <= {rad_reg[WIDE_W-3:0], 2'b00};
                srem_reg <= srem_new;
                root_reg <= root_new;
                if (step_last)
                begin
                    se_o_reg     <= root_sat;
                    mean_o_reg   <= mean_sat;
                    cnt_o_reg    <= cnt_sat;
                    prod_reg     <= cal_gain * mean_sat;
                    status_o_reg <= drop_reg ? STATUS_DROPPED : STATUS_OK;
                end
            end
            BK_CAL:
            begin
                cur_o_reg <= cur_sat;
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== hdl/wmsc_checker.sv =====
module wmsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [wmsc_pkg::FIELD_W-1:0]     out_mean,
    input logic [wmsc_pkg::FIELD_W-1:0]     out_se,
    input logic [wmsc_pkg::COUNT_OUT_W-1:0] out_count,
    input logic [wmsc_pkg::FIELD_W-1:0]     out_current,
    input logic [wmsc_pkg::STATUS_W-1:0]    out_status
);
    import wmsc_pkg::*;
    `include "windowed_mean_stderr_calibrator_assert.svh"

    `WMSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_status) && $stable(out_count), "result dropped while stalled")
    `WMSC_ASSERT_IMPLY(a_empty_zero, out_valid && (out_status == STATUS_EMPTY),
        (out_mean == '0) && (out_se == '0) && (out_count == '0) && (out_current == '0),
        "empty window with nonzero fields")
    `WMSC_ASSERT_IMPLY(a_status_code, out_valid,
        (out_status == STATUS_OK) || (out_status == STATUS_EMPTY)
        || (out_status == STATUS_DROPPED), "bad status code")
    `WMSC_ASSERT_IMPLY(a_count_nonzero, out_valid && (out_status != STATUS_EMPTY),
        out_count != '0, "nonempty window with zero count")
endmodule

bind windowed_mean_stderr_calibrator wmsc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_mean   (results.window_mean),
    .out_se     (results.std_error),
    .out_count  (results.sample_count),
    .out_current(results.calibrated_current),
    .out_status (results.status)
);
